// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the rtd conversion modules
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expects clk_i and rst_ni in the using module
`define RTD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rtd assertion failed");

`define RTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtd assertion failed");

`endif

// File: hdl/rtd_pkg.sv
// ----------------------------------------------------------------------------
// rtd_pkg
// types, widths and polynomial coefficient tables of the rtd converter
// ----------------------------------------------------------------------------
package rtd_pkg;

  localparam int RES_W     = 22;
  localparam int X_W       = 24;
  localparam int ACC_W     = 32;
  localparam int TEMP_W    = 18;
  localparam int MUL_SHIFT = 24;
  localparam int OUT_SHIFT = 11;
  localparam int IN_NORM   = 14;
  localparam int MAX_TERMS = 8;

  localparam int IN_SCALE_PT100  = 9;
  localparam int IN_SCALE_PT1000 = 12;

  localparam logic [RES_W-1:0] ZERO_PT100  = RES_W'(100000);
  localparam logic [RES_W-1:0] ZERO_PT1000 = RES_W'(1000000);

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = {1'b0, {(TEMP_W-1){1'b1}}};
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = {1'b1, {(TEMP_W-1){1'b0}}};

  typedef enum logic {
    SENSOR_PT100  = 1'b0,
    SENSOR_PT1000 = 1'b1
  } rtd_sensor_e;

  typedef logic signed [ACC_W-1:0] rtd_acc_t;
  typedef rtd_acc_t rtd_row_t [MAX_TERMS];

  localparam rtd_row_t POS_PT100 = '{
    -32'sd50339727, 32'sd253398830, 32'sd56041043, -32'sd9105619,
    32'sd27181954, 32'sd0, 32'sd0, 32'sd0};
  localparam rtd_row_t POS_PT1000 = '{
    -32'sd50339727, 32'sd202719064, 32'sd35866267, -32'sd4662077,
    32'sd11133728, 32'sd0, 32'sd0, 32'sd0};
  localparam rtd_row_t NEG_PT100 = '{
    -32'sd49579803, 32'sd239176079, 32'sd141883352, -32'sd173485967,
    32'sd0, 32'sd0, 32'sd0, 32'sd0};
  localparam rtd_row_t NEG_PT1000 = '{
    -32'sd49579803, 32'sd191340863, 32'sd90805345, -32'sd88824815,
    32'sd0, 32'sd0, 32'sd0, 32'sd0};

  typedef struct packed {
    logic [X_W-1:0] x;
    rtd_sensor_e    sensor;
    logic           upper;
  } rtd_ctx_t;

  typedef struct packed {
    rtd_ctx_t ctx;
    rtd_acc_t acc;
  } rtd_beat_t;

  // coefficient of one horner position; terms past the polynomial degree are zero
  function automatic rtd_acc_t rtd_coef(input logic upper, input rtd_sensor_e sensor,
                                        input int idx, input int pos_terms,
                                        input int neg_terms);
    rtd_acc_t c;
    c = '0;
    if (upper) begin
      if (idx < pos_terms) begin
        c = (sensor == SENSOR_PT1000) ? POS_PT1000[idx] : POS_PT100[idx];
      end
    end else begin
      if (idx < neg_terms) begin
        c = (sensor == SENSOR_PT1000) ? NEG_PT1000[idx] : NEG_PT100[idx];
      end
    end
    return c;
  endfunction

endpackage

// File: hdl/rtd_prep.sv
// ----------------------------------------------------------------------------
// rtd_prep
// input scaling, saturation, branch select and leading coefficient
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtd_prep import rtd_pkg::*; #(
  parameter int COEF_IDX  = 4,
  parameter int POS_TERMS = 5,
  parameter int NEG_TERMS = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [RES_W-1:0] resistance_i,
  input  rtd_sensor_e      sensor_i,
  output logic             valid_o,
  input  logic             ready_i,
  output rtd_beat_t        beat_o
);

  localparam int XS_W = RES_W + IN_NORM - IN_SCALE_PT100;

  logic [XS_W-1:0] xs;
  logic [X_W-1:0]  x;
  logic            upper;
  rtd_beat_t       beat_d, beat_q;
  logic            v_q;

  always_comb begin
    if (sensor_i == SENSOR_PT1000) begin
      xs    = XS_W'(resistance_i) << (IN_NORM - IN_SCALE_PT1000);
      upper = resistance_i > ZERO_PT1000;
    end else begin
      xs    = XS_W'(resistance_i) << (IN_NORM - IN_SCALE_PT100);
      upper = resistance_i > ZERO_PT100;
    end
    x = (|xs[XS_W-1:X_W]) ? '1 : xs[X_W-1:0];
    beat_d.ctx.x      = x;
    beat_d.ctx.sensor = sensor_i;
    beat_d.ctx.upper  = upper;
    beat_d.acc        = rtd_coef(upper, sensor_i, COEF_IDX, POS_TERMS, NEG_TERMS);
  end

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign beat_o  = beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      beat_q <= beat_d;
    end
  end

  // pt1000 shift never reaches the saturation limit
  `RTD_ASSERT(a_pt1000_unsat, v_q && beat_q.ctx.sensor == SENSOR_PT1000 |-> beat_q.ctx.x[1:0] == 2'b00)
  `RTD_ASSERT(a_upper_nonzero, v_q && beat_q.ctx.upper |-> beat_q.ctx.x != '0)

endmodule

// File: hdl/rtd_horner_step.sv
// ----------------------------------------------------------------------------
// rtd_horner_step
// one horner step: registered multiply, then truncate and add next coefficient
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtd_horner_step import rtd_pkg::*; #(
  parameter int COEF_IDX  = 0,
  parameter int POS_TERMS = 5,
  parameter int NEG_TERMS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  rtd_beat_t beat_i,
  output logic      valid_o,
  input  logic      ready_i,
  output rtd_beat_t beat_o
);

  localparam int P_W = ACC_W + X_W + 1;

  logic signed [P_W-1:0] a_ext, x_ext, p_d, p_q;
  rtd_ctx_t              m_ctx_q;
  logic                  m_v_q;
  logic                  a_rdy;
  logic                  cin;
  rtd_acc_t              coef;
  rtd_beat_t             a_beat_d, a_beat_q;
  logic                  a_v_q;

  // multiply stage
  always_comb begin
    a_ext = P_W'(beat_i.acc);
    x_ext = P_W'({1'b0, beat_i.ctx.x});
    p_d   = a_ext * x_ext;
  end

  // add stage: floor shift plus carry gives truncation toward zero
  always_comb begin
    cin          = p_q[P_W-1] && (|p_q[MUL_SHIFT-1:0]);
    coef         = rtd_coef(m_ctx_q.upper, m_ctx_q.sensor, COEF_IDX, POS_TERMS, NEG_TERMS);
    a_beat_d.ctx = m_ctx_q;
    a_beat_d.acc = coef + rtd_acc_t'(p_q[ACC_W+MUL_SHIFT-1:MUL_SHIFT]) + rtd_acc_t'(cin);
  end

  assign a_rdy   = !a_v_q || ready_i;
  assign ready_o = !m_v_q || a_rdy;
  assign valid_o = a_v_q;
  assign beat_o  = a_beat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q <= 1'b0;
      a_v_q <= 1'b0;
    end else begin
      if (ready_o) begin
        m_v_q <= valid_i;
      end
      if (a_rdy) begin
        a_v_q <= m_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      p_q     <= p_d;
      m_ctx_q <= beat_i.ctx;
    end
    if (a_rdy && m_v_q) begin
      a_beat_q <= a_beat_d;
    end
  end

  // a product parked behind a stalled add stage must not move
  `RTD_ASSERT_NEXT(a_prod_hold, m_v_q && !a_rdy, m_v_q && $stable(p_q))
  `RTD_ASSERT_NEXT(a_ctx_follow, a_rdy && m_v_q, a_v_q && a_beat_q.ctx == $past(m_ctx_q))

endmodule

// File: hdl/rtd_out.sv
// ----------------------------------------------------------------------------
// rtd_out
// final arithmetic shift, 18-bit saturation and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtd_out import rtd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     ready_o,
  input  rtd_beat_t                beat_i,
  output logic                     valid_o,
  input  logic                     ready_i,
  output logic signed [TEMP_W-1:0] temp_o
);

  localparam int HI = OUT_SHIFT + TEMP_W - 1;

  logic [ACC_W-1:HI]        top_bits;
  logic                     ovf;
  logic signed [TEMP_W-1:0] temp_d, temp_q;
  logic                     v_q;

  always_comb begin
    top_bits = beat_i.acc[ACC_W-1:HI];
    // shifted value fits only if the bits above its sign all match
    ovf = !((&top_bits) || !(|top_bits));
    if (ovf) begin
      temp_d = beat_i.acc[ACC_W-1] ? TEMP_MIN : TEMP_MAX;
    end else begin
      temp_d = beat_i.acc[HI:OUT_SHIFT];
    end
  end

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign temp_o  = temp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      temp_q <= temp_d;
    end
  end

  // floor shift and clamp both keep the sign of the sum
  `RTD_ASSERT_NEXT(a_sign_kept, valid_i && ready_o, temp_q[TEMP_W-1] == $past(beat_i.acc[ACC_W-1]))

endmodule

// File: hdl/rtd_resistance_to_temperature.sv
// ----------------------------------------------------------------------------
// rtd_resistance_to_temperature
// pt100 / pt1000 resistance to temperature by pipelined horner evaluation
// ----------------------------------------------------------------------------
//  channel  dir  tdata                         tuser
//  s_axis   in   [21:0] resistance, mohm       [0] sensor_type (1 = pt1000)
//  m_axis   out  [17:0] temperature, 0.01 degC -
//
//  one beat per cycle sustained while m_axis_tready holds; stages in order:
//  scaling stage, a multiply and an add stage per horner step, output stage
//  each stage holds its own valid bit and fills bubbles while the output stalls
//  s_axis_tready drops only when every stage holds a beat and m_axis stalls
//  reset clears the valid bits only; no state survives between beats
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtd_resistance_to_temperature import rtd_pkg::*; #(
  parameter int POS_TERMS = 5,
  parameter int NEG_TERMS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [21:0] resistance
  input  logic        s_axis_tuser,   // [0] sensor_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [17:0] temperature
);

  localparam int NUM_STEPS = ((POS_TERMS > NEG_TERMS) ? POS_TERMS : NEG_TERMS) - 1;

  rtd_beat_t                beat_s [NUM_STEPS+1];
  logic                     vld_s  [NUM_STEPS+1];
  logic                     rdy_s  [NUM_STEPS+1];
  logic signed [TEMP_W-1:0] temp;

  rtd_prep #(
    .COEF_IDX  (NUM_STEPS),
    .POS_TERMS (POS_TERMS),
    .NEG_TERMS (NEG_TERMS)
  ) u_prep (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .resistance_i (s_axis_tdata[RES_W-1:0]),
    .sensor_i     (rtd_sensor_e'(s_axis_tuser)),
    .valid_o      (vld_s[0]),
    .ready_i      (rdy_s[0]),
    .beat_o       (beat_s[0])
  );

  for (genvar k = 1; k <= NUM_STEPS; k++) begin : g_step
    rtd_horner_step #(
      .COEF_IDX  (NUM_STEPS - k),
      .POS_TERMS (POS_TERMS),
      .NEG_TERMS (NEG_TERMS)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld_s[k-1]),
      .ready_o (rdy_s[k-1]),
      .beat_i  (beat_s[k-1]),
      .valid_o (vld_s[k]),
      .ready_i (rdy_s[k]),
      .beat_o  (beat_s[k])
    );
  end

  rtd_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vld_s[NUM_STEPS]),
    .ready_o (rdy_s[NUM_STEPS]),
    .beat_i  (beat_s[NUM_STEPS]),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .temp_o  (temp)
  );

  assign m_axis_tdata = {{(24-TEMP_W){1'b0}}, temp};

  // input back-pressure only comes from a full pipe behind a stalled output
  `RTD_ASSERT(a_full_stall, !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)

endmodule
